>>> sv/cda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg
// Types, operation codes and calendar helpers shared by the date unit modules.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam logic [2:0] OP_ADD_DAYS   = 3'd0;
  localparam logic [2:0] OP_SUB_DAYS   = 3'd1;
  localparam logic [2:0] OP_ADD_MONTHS = 3'd2;
  localparam logic [2:0] OP_SUB_MONTHS = 3'd3;
  localparam logic [2:0] OP_ADD_YEARS  = 3'd4;
  localparam logic [2:0] OP_SUB_YEARS  = 3'd5;
  localparam logic [2:0] OP_COMPARE    = 3'd6;
  localparam logic [2:0] OP_WEEKDAY    = 3'd7;

  localparam logic [1:0] ORD_EARLIER = 2'b11;
  localparam logic [1:0] ORD_EQUAL   = 2'b00;
  localparam logic [1:0] ORD_LATER   = 2'b01;

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  typedef struct packed {
    logic [2:0]  operation;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] amount;
    logic [13:0] other_year;
    logic [3:0]  other_month;
    logic [4:0]  other_day;
  } in_t;

  typedef struct packed {
    logic [13:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic [1:0]  order;
    logic [2:0]  weekday;
    logic        range_error;
  } out_t;

  // Queue entry: raw request plus the clamped month and day and the leap flag
  typedef struct packed {
    in_t        req;
    logic [3:0] nmonth;
    logic [4:0] nday;
    logic       leap;
  } entry_t;

  // Quotient by 100 through a reciprocal multiply, exact below 32768
  function automatic logic [8:0] div100(input logic [14:0] y);
    logic [27:0] prod;
    begin
      prod = {13'd0, y} * 28'd5243;
      div100 = prod[27:19];
    end
  endfunction

  function automatic logic is_leap(input logic [14:0] y);
    logic [8:0]  q;
    logic [15:0] qh;
    logic [14:0] r;
    begin
      q  = div100(y);
      qh = {7'd0, q} * 16'd100;
      r  = y - qh[14:0];
      is_leap = (y[1:0] == 2'd0 && r != 15'd0) || (r == 15'd0 && q[1:0] == 2'd0);
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    begin
      unique case (m)
        4'd2:                       month_len = lp ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
        default:                    month_len = 5'd31;
      endcase
    end
  endfunction

  // floor(13 * (m + 1) / 5) for the shifted month 3..14
  function automatic logic [5:0] zeller_month(input logic [3:0] m);
    begin
      unique case (m)
        4'd3:    zeller_month = 6'd10;
        4'd4:    zeller_month = 6'd13;
        4'd5:    zeller_month = 6'd15;
        4'd6:    zeller_month = 6'd18;
        4'd7:    zeller_month = 6'd20;
        4'd8:    zeller_month = 6'd23;
        4'd9:    zeller_month = 6'd26;
        4'd10:   zeller_month = 6'd28;
        4'd11:   zeller_month = 6'd31;
        4'd12:   zeller_month = 6'd33;
        4'd13:   zeller_month = 6'd36;
        4'd14:   zeller_month = 6'd39;
        default: zeller_month = 6'd0;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/cda_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_front
// Clamps month and day of an incoming request and tags its year as leap.
// ----------------------------------------------------------------------------
module cda_front (
  input  wire cda_pkg::in_t    request,
  output cda_pkg::entry_t      entry
);

  logic [3:0] m0;
  logic       lp;
  logic [4:0] len;

  always_comb begin
    lp = cda_pkg::is_leap({1'b0, request.year});
    priority if (request.month == 4'd0) m0 = 4'd1;
    else if (request.month > 4'd12)     m0 = 4'd12;
    else                                m0 = request.month;
    len = cda_pkg::month_len(m0, lp);
    entry.req    = request;
    entry.nmonth = m0;
    entry.leap   = lp;
    priority if (request.day == 5'd0) entry.nday = 5'd1;
    else if (request.day > len)       entry.nday = len;
    else                              entry.nday = request.day;
  end

endmodule
`default_nettype wire

>>> sv/cda_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_queue
// Two-entry register queue between the front and the back.
// ----------------------------------------------------------------------------
module cda_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr,
  input  wire cda_pkg::entry_t wdata,
  output logic                 full,
  input  wire                  rd,
  output cda_pkg::entry_t      rdata,
  output logic                 empty
);

  cda_pkg::entry_t slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      count <= count + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end

endmodule
`default_nettype wire

>>> sv/cda_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cda_back
// Sequencer that carries out one queued request and holds its result.
// ----------------------------------------------------------------------------
module cda_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  q_empty,
  input  wire cda_pkg::entry_t q_entry,
  output logic                 q_pop,
  output logic                 empty,
  input  wire                  pop,
  output cda_pkg::out_t        result
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_SUB, S_MON1, S_MON2, S_MON3, S_YR,
    S_LEAP, S_W1, S_W2, S_W3, S_FIN
  } state_t;

  state_t              state;
  state_t              ret;
  logic signed [19:0]  y;
  logic [3:0]          m;
  logic [4:0]          d;
  logic [15:0]         n;
  logic                lp;
  cda_pkg::in_t        req;
  logic [12:0]         q12;
  logic [3:0]          r12;
  logic [8:0]          wj;
  logic [6:0]          wk;
  logic [10:0]         wh;
  logic [1:0]          ord;
  logic [2:0]          wd;
  logic                ovalid;

  logic [4:0]  len;
  logic [16:0] dsum;
  logic [32:0] p12;
  logic [16:0] q12x;
  logic [4:0]  m0;
  logic [4:0]  madd;
  logic [14:0] yz;
  logic [3:0]  mz;
  logic [8:0]  j100;
  logic [15:0] jh;
  logic [27:0] p7;
  logic [13:0] q7x;
  logic [3:0]  r7;
  logic        is_mod;
  logic [1:0]  ord_in;
  cda_pkg::out_t res_next;

  always_comb begin
    len  = cda_pkg::month_len(m, lp);
    dsum = {12'd0, d} + {1'b0, n};
    p12  = {17'd0, req.amount} * 33'd43691;
    q12x = {4'd0, q12} * 17'd12;
    // remainder of the month amount by 12, valid once q12 is loaded
    r12  = req.amount[3:0] - q12x[3:0];
    m0   = {1'b0, m} - 5'd1;
    madd = m0 + {1'b0, r12};
    mz   = (m < 4'd3) ? m + 4'd12 : m;
    yz   = y[14:0] - {14'd0, m < 4'd3} + 15'd400;
    j100 = cda_pkg::div100(yz);
    jh   = {7'd0, j100} * 16'd100;
    p7   = {17'd0, wh} * 28'd9363;
    q7x  = {6'd0, p7[23:16]} * 14'd7;
    r7   = wh[3:0] - q7x[3:0];
    is_mod = req.operation < cda_pkg::OP_COMPARE;
  end

  // Order of the raw dates, field by field
  always_comb begin
    priority if (q_entry.req.operation != cda_pkg::OP_COMPARE)
      ord_in = cda_pkg::ORD_EQUAL;
    else if (q_entry.req.year != q_entry.req.other_year)
      ord_in = (q_entry.req.year < q_entry.req.other_year) ?
               cda_pkg::ORD_EARLIER : cda_pkg::ORD_LATER;
    else if (q_entry.req.month != q_entry.req.other_month)
      ord_in = (q_entry.req.month < q_entry.req.other_month) ?
               cda_pkg::ORD_EARLIER : cda_pkg::ORD_LATER;
    else if (q_entry.req.day != q_entry.req.other_day)
      ord_in = (q_entry.req.day < q_entry.req.other_day) ?
               cda_pkg::ORD_EARLIER : cda_pkg::ORD_LATER;
    else
      ord_in = cda_pkg::ORD_EQUAL;
  end

  // Final result, clamped when a date operation takes the year out of 1..9999
  always_comb begin
    res_next.order       = ord;
    res_next.weekday     = wd;
    priority if (is_mod && y < 20'sd1) begin
      res_next.range_error  = 1'b1;
      res_next.result_year  = 14'd1;
      res_next.result_month = 4'd1;
      res_next.result_day   = 5'd1;
    end else if (is_mod && y > 20'sd9999) begin
      res_next.range_error  = 1'b1;
      res_next.result_year  = cda_pkg::YEAR_MAX;
      res_next.result_month = 4'd12;
      res_next.result_day   = 5'd31;
    end else begin
      res_next.range_error  = 1'b0;
      res_next.result_year  = is_mod ? y[13:0] : req.year;
      res_next.result_month = is_mod ? m : req.month;
      res_next.result_day   = is_mod ? d : req.day;
    end
  end

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (pop && ovalid) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            req <= q_entry.req;
            m   <= q_entry.nmonth;
            d   <= q_entry.nday;
            n   <= q_entry.req.amount;
            lp  <= q_entry.leap;
            ord <= ord_in;
            wd  <= 3'd0;
            unique case (q_entry.req.operation)
              cda_pkg::OP_ADD_DAYS: begin
                y     <= {6'd0, q_entry.req.year};
                state <= S_ADD;
              end
              cda_pkg::OP_SUB_DAYS: begin
                y     <= {6'd0, q_entry.req.year};
                state <= S_SUB;
              end
              cda_pkg::OP_ADD_MONTHS,
              cda_pkg::OP_SUB_MONTHS: begin
                y     <= {6'd0, q_entry.req.year};
                state <= S_MON1;
              end
              // year ops: apply the shift now, fix Feb 29 after the leap check
              cda_pkg::OP_ADD_YEARS: begin
                y     <= {6'd0, q_entry.req.year} + {4'd0, q_entry.req.amount};
                ret   <= S_YR;
                state <= S_LEAP;
              end
              cda_pkg::OP_SUB_YEARS: begin
                y     <= {6'd0, q_entry.req.year} - {4'd0, q_entry.req.amount};
                ret   <= S_YR;
                state <= S_LEAP;
              end
              cda_pkg::OP_COMPARE: begin
                y     <= {6'd0, q_entry.req.year};
                state <= S_FIN;
              end
              default: begin
                y     <= {6'd0, q_entry.req.year};
                state <= S_W1;
              end
            endcase
          end
        end
        // Walk forward one month per cycle, through S_LEAP at each year crossed
        S_ADD: begin
          if (n == 16'd0) begin
            state <= S_FIN;
          end else if (dsum <= {12'd0, len}) begin
            d     <= dsum[4:0];
            state <= S_FIN;
          end else begin
            n <= n - {11'd0, len - d + 5'd1};
            d <= 5'd1;
            if (m == 4'd12) begin
              m     <= 4'd1;
              y     <= y + 20'sd1;
              ret   <= S_ADD;
              state <= S_LEAP;
            end else begin
              m <= m + 4'd1;
            end
          end
        end
        // Walk backward one month per cycle, through S_LEAP at each year crossed
        S_SUB: begin
          if (n == 16'd0) begin
            state <= S_FIN;
          end else if ({11'd0, d} > n) begin
            d     <= d - n[4:0];
            state <= S_FIN;
          end else begin
            n <= n - {11'd0, d};
            if (m == 4'd1) begin
              m     <= 4'd12;
              d     <= 5'd31;
              y     <= y - 20'sd1;
              ret   <= S_SUB;
              state <= S_LEAP;
            end else begin
              m <= m - 4'd1;
              d <= cda_pkg::month_len(m - 4'd1, lp);
            end
          end
        end
        S_MON1: begin
          q12   <= p12[31:19];
          state <= S_MON2;
        end
        S_MON2: begin
          if (req.operation == cda_pkg::OP_ADD_MONTHS) begin
            if (madd >= 5'd12) begin
              m <= madd[3:0] - 4'd11;
              y <= y + {7'd0, q12} + 20'sd1;
            end else begin
              m <= madd[3:0] + 4'd1;
              y <= y + {7'd0, q12};
            end
          end else begin
            if ({1'b0, r12} > m0) begin
              m <= m0[3:0] + 4'd13 - r12;
              y <= y - {7'd0, q12} - 20'sd1;
            end else begin
              m <= m0[3:0] + 4'd1 - r12;
              y <= y - {7'd0, q12};
            end
          end
          ret   <= S_MON3;
          state <= S_LEAP;
        end
        S_MON3: begin
          if (d > len) d <= len;
          state <= S_FIN;
        end
        S_YR: begin
          if (m == 4'd2 && d == 5'd29 && !lp) d <= 5'd28;
          state <= S_FIN;
        end
        S_LEAP: begin
          lp    <= cda_pkg::is_leap(y[14:0]);
          state <= ret;
        end
        S_W1: begin
          wj    <= j100;
          wk    <= yz[6:0] - jh[6:0];
          wh    <= {7'd0, mz};
          state <= S_W2;
        end
        S_W2: begin
          wh <= {6'd0, d} + {5'd0, cda_pkg::zeller_month(wh[3:0])} + {4'd0, wk}
                + {6'd0, wk[6:2]} + {4'd0, wj[8:2]}
                + ({2'd0, wj} + {wj, 2'b00});
          state <= S_W3;
        end
        S_W3: begin
          wd    <= ((r7 + 4'd5) >= 4'd7) ? 3'(r7 - 4'd2) : 3'(r7 + 4'd5);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!ovalid) begin
            ovalid <= 1'b1;
            result <= res_next;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE) else $error("queue read outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !pop |=> ovalid && $stable(result)) else $error("result lost");
  a_err: assert property (@(posedge clk) disable iff (rst)
    ovalid && result.range_error |->
      (result.result_year == 14'd1 || result.result_year == cda_pkg::YEAR_MAX))
    else $error("range flag without clamp");
  a_ord: assert property (@(posedge clk) disable iff (rst)
    ovalid && result.order != cda_pkg::ORD_EQUAL |-> result.weekday == 3'd0)
    else $error("order and weekday both set");

endmodule
`default_nettype wire

>>> sv/calendar_date_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit
// Gregorian date arithmetic: day, month and year offsets, compare, weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as a queue push: drive request with push high; the
//   request is taken at a clock edge where full is low. Results leave as a
//   queue: while empty is low, result holds the oldest result; pop high at
//   an edge takes it.
//   The front clamps month and day and tags the leap year as the request
//   is pushed; a two-entry queue lets it take two more requests while the
//   back is busy. The back runs one request at a time, in these states:
//     compare            S_FIN
//     add/sub years      S_LEAP, S_YR, S_FIN
//     add/sub months     S_MON1, S_MON2, S_LEAP, S_MON3, S_FIN
//     weekday            S_W1, S_W2, S_W3, S_FIN
//     add/sub days       S_ADD or S_SUB once per month walked, S_LEAP per
//                        year crossed, then S_FIN; up to 65535 days.
//   The month walk of the day operations runs longest. An accepted request
//   passes the queue register and the back's states to the result register.
//   When the receiver stalls, the result register holds; the back waits
//   with its next result and the queue fills, then full rises.
//   Reset (rst, synchronous) empties the queue and the result register.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_unit (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire cda_pkg::in_t  request,
  output logic               empty,
  input  wire                pop,
  output cda_pkg::out_t      result
);

  cda_pkg::entry_t wentry;
  cda_pkg::entry_t rentry;
  logic            q_empty;
  logic            q_pop;

  // Classify and clamp on the way in
  cda_front u_front (
    .request (request),
    .entry   (wentry)
  );

  // Decouple front from back
  cda_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (wentry),
    .full  (full),
    .rd    (q_pop),
    .rdata (rentry),
    .empty (q_empty)
  );

  // Carry out requests and hold the result until popped
  cda_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_entry (rentry),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire
